FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// ante implies cons in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// ante implies cons in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/pila_pkg.sv
// ----------------------------------------------------------------------------
// pila_pkg
// Shared types and constants of the pixel input location assigner.
// ----------------------------------------------------------------------------
package pila_pkg;

	localparam int NUM_LOCATIONS_DEF = 32;
	localparam int MAX_ACTIVE_DEF    = 32;

	localparam int LOC_W     = 5;
	localparam int IDX_W     = 5;
	localparam int WORD_W    = 32;
	localparam int CMD_W     = 2;
	localparam int STAT_W    = 2;
	localparam int CNT_W     = 6;
	localparam int SET_W     = LOC_W + 1;
	localparam int LOC_DEPTH = 1 << LOC_W;
	localparam int NUM_IDX   = 1 << IDX_W;
	localparam int GROUPS    = 2 * LOC_DEPTH;
	localparam int FLAT_BIT  = 10;

	localparam int IDX_LSB   = 0;
	localparam int WORD_LSB  = IDX_LSB + IDX_W;
	localparam int S_DATA_W  = ((WORD_LSB + WORD_W + 7) / 8) * 8;
	localparam int STAT_LSB  = LOC_W;
	localparam int M_DATA_W  = ((STAT_LSB + STAT_W + 7) / 8) * 8;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUSTOM_MASK = 1'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_NOFREE = 2'd1,
		STAT_FULL   = 2'd2
	} stat_t;

endpackage

FILE: sv/pila_ram.sv
// ----------------------------------------------------------------------------
// pila_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pila_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/pixel_input_location_assigner.sv
// ----------------------------------------------------------------------------
// pixel_input_location_assigner
// Keeps pixel-shader input settings and an active input list, and answers
// location queries with flat/smooth conflict resolution.
// ----------------------------------------------------------------------------
// One word in, one word out. Write, append and clear go straight to the
// response state. A query first makes one pass over the active list that
// marks used locations, then walks the entries; each walked entry takes a
// list read, a setting read, a group row read and an update in turn, since
// the list, setting and group memories each have a single read port. The
// walk stops at the first entry matching the queried input. Input is taken
// only while no word is in progress; a finished result waits in an output
// register. Settings reset to zero via per-entry valid flops, so no
// clearing pass is needed.
`include "assert_macros.svh"

module pixel_input_location_assigner #(
	parameter int NUM_LOCATIONS = pila_pkg::NUM_LOCATIONS_DEF,
	parameter int MAX_ACTIVE    = pila_pkg::MAX_ACTIVE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pila_pkg::S_DATA_W-1:0]    s_tdata,   // input_index, setting_word
	input  logic [pila_pkg::CMD_W-1:0]       s_tuser,   // command
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pila_pkg::M_DATA_W-1:0]    m_tdata,   // location, status
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pila_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pila_pkg::WORD_W-1:0]      cfg_data
);

	import pila_pkg::*;

	localparam int LENW = $clog2(MAX_ACTIVE + 1);
	localparam int LW   = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
	localparam int GW   = LOC_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_RESP, ST_QSET, ST_MARK, ST_WA, ST_WB, ST_WC, ST_WD
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         input_count_q;
	logic [NUM_IDX-1:0]       custom_mask_q;
	logic [NUM_IDX-1:0]       set_valid_q;
	logic [LENW-1:0]          len_q;
	logic [NUM_LOCATIONS-1:0] used_q;
	logic [GROUPS-1:0]        gv_q;
	logic                     err_q;
	logic [IDX_W-1:0]         target_q;
	logic [LOC_W-1:0]         target_map_q;
	logic [IDX_W-1:0]         ent_q;
	logic [LOC_W-1:0]         m_q;
	logic                     f_q;
	logic [LENW-1:0]          i_q;
	logic [LENW-1:0]          mi_q;
	logic                     issue_s1;
	logic                     v_s2;
	logic [IDX_W-1:0]         ent_s2;
	logic [LOC_W-1:0]         res_loc_q;
	stat_t                    res_stat_q;
	logic                     m_tvalid_q;
	logic [LOC_W-1:0]         out_loc_q;
	stat_t                    out_stat_q;

	cmd_t             in_cmd;
	logic [IDX_W-1:0] in_idx;
	logic [WORD_W-1:0] in_word;
	logic             in_acc;

	logic               set_we;
	logic [IDX_W-1:0]   set_raddr;
	logic [SET_W-1:0]   set_wdata;
	logic [SET_W-1:0]   set_rdata;
	logic               lst_we;
	logic [LW-1:0]      lst_raddr;
	logic [IDX_W-1:0]   lst_rdata;
	logic               grp_we;
	logic [2*LOC_W-1:0] grp_wdata;
	logic [2*LOC_W-1:0] grp_rdata;

	logic [LOC_W-1:0] qm;
	logic [LOC_W-1:0] km;
	logic [LOC_W-1:0] wm;
	logic             wf;
	logic [GW-1:0]    g_self;
	logic [GW-1:0]    g_other;
	logic [LOC_W-1:0] half_old;
	logic             free_found;
	logic [LOC_W-1:0] free_loc;
	logic             new_grp;
	logic             conflict;
	logic             fail;
	logic [LOC_W-1:0] assign_loc;
	logic [LOC_W-1:0] grp_loc;
	logic             err_n;

	function automatic logic [LOC_W-1:0] map_of(input logic [IDX_W-1:0] idx,
			input logic [SET_W-1:0] sd, input logic sv, input logic [CNT_W-1:0] cnt);
		logic [SET_W-1:0] eff;
		eff = sv ? sd : '0;
		return ({1'b0, idx} < cnt) ? eff[LOC_W-1:0] : idx;
	endfunction

	function automatic logic flat_of(input logic [IDX_W-1:0] idx,
			input logic [SET_W-1:0] sd, input logic sv, input logic [CNT_W-1:0] cnt,
			input logic [NUM_IDX-1:0] cmask);
		return ({1'b0, idx} < cnt) && sv && sd[LOC_W] && !cmask[idx];
	endfunction

	function automatic logic [NUM_LOCATIONS-1:0] mark_bit(input logic [LOC_W-1:0] loc);
		if ({1'b0, loc} < (LOC_W + 1)'(NUM_LOCATIONS)) begin
			return NUM_LOCATIONS'(1) << loc;
		end
		return '0;
	endfunction

	assign in_cmd   = cmd_t'(s_tuser);
	assign in_idx   = s_tdata[IDX_LSB +: IDX_W];
	assign in_word  = s_tdata[WORD_LSB +: WORD_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// memory ports
	assign set_we    = in_acc && (in_cmd == CMD_WRITE);
	assign set_wdata = {in_word[FLAT_BIT], in_word[LOC_W-1:0]};
	assign set_raddr = (state_q == ST_MARK || state_q == ST_WB) ? lst_rdata : in_idx;
	assign lst_we    = in_acc && (in_cmd == CMD_APPEND) && (len_q < LENW'(MAX_ACTIVE));
	assign lst_raddr = (state_q == ST_MARK) ? mi_q[LW-1:0] : i_q[LW-1:0];

	always_comb begin
		qm = map_of(target_q, set_rdata, set_valid_q[target_q], input_count_q);
		km = map_of(ent_s2, set_rdata, set_valid_q[ent_s2], input_count_q);
		wm = map_of(ent_q, set_rdata, set_valid_q[ent_q], input_count_q);
		wf = flat_of(ent_q, set_rdata, set_valid_q[ent_q], input_count_q, custom_mask_q);
	end

	// lowest free location
	always_comb begin
		free_found = 1'b0;
		free_loc   = '0;
		for (int k = NUM_LOCATIONS - 1; k >= 0; k--) begin
			if (!used_q[k]) begin
				free_found = 1'b1;
				free_loc   = LOC_W'(k);
			end
		end
	end

	always_comb begin
		g_self     = {m_q, f_q};
		g_other    = {m_q, ~f_q};
		half_old   = f_q ? grp_rdata[2*LOC_W-1:LOC_W] : grp_rdata[LOC_W-1:0];
		new_grp    = !gv_q[g_self];
		conflict   = gv_q[g_other];
		fail       = new_grp && conflict && !free_found;
		assign_loc = conflict ? (free_found ? free_loc : '0) : m_q;
		grp_loc    = new_grp ? assign_loc : half_old;
		err_n      = err_q || fail;
		grp_we     = (state_q == ST_WD) && new_grp;
		grp_wdata  = f_q ? {assign_loc, grp_rdata[LOC_W-1:0]}
		                 : {grp_rdata[2*LOC_W-1:LOC_W], assign_loc};
	end

	pila_ram #(.WIDTH(SET_W), .DEPTH(NUM_IDX)) u_set_ram (
		.clk   (clk),
		.we    (set_we),
		.waddr (in_idx),
		.wdata (set_wdata),
		.raddr (set_raddr),
		.rdata (set_rdata)
	);

	pila_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ACTIVE)) u_list_ram (
		.clk   (clk),
		.we    (lst_we),
		.waddr (len_q[LW-1:0]),
		.wdata (in_idx),
		.raddr (lst_raddr),
		.rdata (lst_rdata)
	);

	pila_ram #(.WIDTH(2 * LOC_W), .DEPTH(LOC_DEPTH)) u_grp_ram (
		.clk   (clk),
		.we    (grp_we),
		.waddr (m_q),
		.wdata (grp_wdata),
		.raddr (wm),
		.rdata (grp_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_count_q <= '0;
			custom_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INPUT_COUNT: input_count_q <= cfg_data[CNT_W-1:0];
				CFG_CUSTOM_MASK: custom_mask_q <= cfg_data[NUM_IDX-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			set_valid_q  <= '0;
			len_q        <= '0;
			used_q       <= '0;
			gv_q         <= '0;
			err_q        <= 1'b0;
			target_q     <= '0;
			target_map_q <= '0;
			ent_q        <= '0;
			m_q          <= '0;
			f_q          <= 1'b0;
			i_q          <= '0;
			mi_q         <= '0;
			issue_s1     <= 1'b0;
			v_s2         <= 1'b0;
			ent_s2       <= '0;
			res_loc_q    <= '0;
			res_stat_q   <= STAT_OK;
			m_tvalid_q   <= 1'b0;
			out_loc_q    <= '0;
			out_stat_q   <= STAT_OK;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_RESP)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						res_loc_q  <= '0;
						res_stat_q <= STAT_OK;
						state_q    <= ST_RESP;
						case (in_cmd)
							CMD_WRITE: set_valid_q[in_idx] <= 1'b1;
							CMD_APPEND: begin
								if (len_q < LENW'(MAX_ACTIVE)) begin
									len_q <= len_q + 1'b1;
								end else begin
									res_stat_q <= STAT_FULL;
								end
							end
							CMD_QUERY: begin
								target_q <= in_idx;
								used_q   <= '0;
								gv_q     <= '0;
								err_q    <= 1'b0;
								i_q      <= '0;
								mi_q     <= '0;
								issue_s1 <= 1'b0;
								v_s2     <= 1'b0;
								state_q  <= ST_QSET;
							end
							CMD_CLEAR: len_q <= '0;
							default: ;
						endcase
					end
				end
				ST_QSET: begin
					target_map_q <= qm;
					state_q      <= ST_MARK;
				end
				ST_MARK: begin
					// list read -> setting read -> mark
					issue_s1 <= (mi_q < len_q);
					if (mi_q < len_q) begin
						mi_q <= mi_q + 1'b1;
					end
					v_s2 <= issue_s1;
					if (issue_s1) begin
						ent_s2 <= lst_rdata;
					end
					if (v_s2) begin
						used_q <= used_q | mark_bit(km);
					end
					if ((mi_q == len_q) && !issue_s1 && !v_s2) begin
						state_q <= ST_WA;
					end
				end
				ST_WA: begin
					if (i_q >= len_q) begin
						res_loc_q  <= target_map_q;
						res_stat_q <= err_q ? STAT_NOFREE : STAT_OK;
						state_q    <= ST_RESP;
					end else begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					ent_q   <= lst_rdata;
					state_q <= ST_WC;
				end
				ST_WC: begin
					m_q     <= wm;
					f_q     <= wf;
					state_q <= ST_WD;
				end
				ST_WD: begin
					if (new_grp) begin
						gv_q[g_self] <= 1'b1;
					end
					if (new_grp && !fail) begin
						used_q <= used_q | mark_bit(assign_loc);
					end
					err_q <= err_n;
					if (ent_q == target_q) begin
						res_loc_q  <= grp_loc;
						res_stat_q <= err_n ? STAT_NOFREE : STAT_OK;
						state_q    <= ST_RESP;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_WA;
					end
				end
				ST_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						out_loc_q  <= res_loc_q;
						out_stat_q <= res_stat_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'({out_stat_q, out_loc_q});

	`ASSERT_ALWAYS(a_len_bound, clk, arst_n, len_q <= LENW'(MAX_ACTIVE))
	`ASSERT_IMPL(a_walk_in_list, clk, arst_n, state_q == ST_WB, i_q < len_q)
	`ASSERT_NEXT(a_query_start, clk, arst_n, in_acc && in_cmd == CMD_QUERY, state_q == ST_QSET && used_q == '0 && gv_q == '0 && !err_q)

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the pixel input location assigner. Words are driven
// on the falling edge with random gaps on both sides. Each accepted input
// word is run through a local model of the settings, the active list and the
// flat/smooth group walk, and every result word is compared field by field
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_top;
	import pila_pkg::*;

	localparam int NLOC      = NUM_LOCATIONS_DEF;
	localparam int NACT      = MAX_ACTIVE_DEF;
	localparam int SETTLE    = 20;
	localparam int HOLD_LEN  = 400;

	typedef struct packed {
		logic [LOC_W-1:0] loc;
		stat_t            st;
	} answer_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata;
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [WORD_W-1:0]     cfg_data;

	pixel_input_location_assigner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow state
	logic [CNT_W-1:0]   num_inputs;
	logic [WORD_W-1:0]  custom_bits;
	logic [LOC_W-1:0]   tbl_loc [NUM_IDX];
	logic               tbl_flat [NUM_IDX];
	logic [IDX_W-1:0]   act_list [NACT];
	int                 act_len;

	answer_t            answer_q[$];
	int                 n_err;
	int                 n_words;
	int                 n_queries;
	int                 n_moved;
	int                 n_full;
	int                 n_cfg;
	bit                 steady;
	bit                 hold_req;
	int                 stall_left;

	answer_t            chk_exp;
	logic [LOC_W-1:0]   chk_loc;
	logic [STAT_W-1:0]  chk_st;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("timeout");
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic logic [LOC_W-1:0] mapped_loc(logic [IDX_W-1:0] i);
		return ({1'b0, i} < num_inputs) ? tbl_loc[i] : i;
	endfunction

	function automatic logic is_flat(logic [IDX_W-1:0] i);
		return ({1'b0, i} < num_inputs) && tbl_flat[i] && !custom_bits[i];
	endfunction

	// apply one accepted word to the shadow state, return its answer
	function automatic answer_t assign_word(cmd_t c, logic [IDX_W-1:0] idx,
			logic [WORD_W-1:0] w);
		answer_t           r;
		logic [NLOC-1:0]   used;
		logic [GROUPS-1:0] slot_v;
		logic [LOC_W-1:0]  slot_l [GROUPS];
		logic [LOC_W-1:0]  m;
		int                k;
		int                g;
		int                free;
		logic              ok;
		logic              err;
		logic              found;
		r.loc = '0;
		r.st = STAT_OK;
		case (c)
			CMD_WRITE: begin
				tbl_loc[idx] = w[LOC_W-1:0];
				tbl_flat[idx] = w[FLAT_BIT];
			end
			CMD_APPEND: begin
				if (act_len < NACT) begin
					act_list[act_len] = idx;
					act_len++;
				end else begin
					r.st = STAT_FULL;
					n_full++;
				end
			end
			CMD_QUERY: begin
				n_queries++;
				used = '0;
				slot_v = '0;
				for (k = 0; k < act_len; k++)
					used[mapped_loc(act_list[k])] = 1'b1;
				err = 1'b0;
				found = 1'b0;
				for (k = 0; k < act_len && !found; k++) begin
					m = mapped_loc(act_list[k]);
					g = m * 2 + is_flat(act_list[k]);
					if (!slot_v[g]) begin
						ok = 1'b1;
						slot_l[g] = m;
						if (slot_v[g ^ 1]) begin
							free = 0;
							while (free < NLOC && used[free])
								free++;
							if (free >= NLOC) begin
								slot_l[g] = '0;
								ok = 1'b0;
								err = 1'b1;
							end else begin
								slot_l[g] = LOC_W'(free);
							end
						end
						slot_v[g] = 1'b1;
						if (ok)
							used[slot_l[g]] = 1'b1;
					end
					if (act_list[k] == idx) begin
						found = 1'b1;
						r.loc = slot_l[g];
					end
				end
				if (!found)
					r.loc = mapped_loc(idx);
				else if (r.loc != mapped_loc(idx))
					n_moved++;
				r.st = err ? STAT_NOFREE : STAT_OK;
			end
			default: begin
				act_len = 0;
			end
		endcase
		return r;
	endfunction

	task automatic send_word(cmd_t c, logic [IDX_W-1:0] idx, logic [WORD_W-1:0] w);
		int gap;
		@(negedge clk);
		gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = c;
		s_tdata = S_DATA_W'({w, idx});
		do @(posedge clk); while (!s_tready);
		answer_q.push_back(assign_word(c, idx, w));
		n_words++;
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] ri, logic [WORD_W-1:0] d);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = ri;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		if (ri == CFG_INPUT_COUNT)
			num_inputs = d[CNT_W-1:0];
		else
			custom_bits = d;
		n_cfg++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(logic [CNT_W-1:0] cnt, logic [WORD_W-1:0] mask);
		drain();
		cfg_write(CFG_INPUT_COUNT, {{(WORD_W-CNT_W){1'b0}}, cnt});
		cfg_write(CFG_CUSTOM_MASK, mask);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [IDX_W-1:0] pick_idx();
		if ($urandom_range(0, 9) < 7) return IDX_W'($urandom_range(0, 11));
		return IDX_W'($urandom_range(0, 31));
	endfunction

	function automatic logic [WORD_W-1:0] pick_setting();
		logic [WORD_W-1:0] w;
		w = $urandom;
		if ($urandom_range(0, 4) != 0)
			w[LOC_W-1:0] = LOC_W'($urandom_range(0, 7));
		return w;
	endfunction

	function automatic logic [IDX_W-1:0] pick_target();
		if (act_len > 0 && $urandom_range(0, 3) != 0)
			return act_list[$urandom_range(0, act_len - 1)];
		return IDX_W'($urandom_range(0, 31));
	endfunction

	task automatic send_noise();
		send_word(cmd_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 31)), $urandom);
	endtask

	task automatic run_scene(int len, bit do_clear);
		int k;
		if (do_clear)
			send_word(CMD_CLEAR, IDX_W'($urandom_range(0, 31)), $urandom);
		repeat ($urandom_range(4, 10))
			send_word(CMD_WRITE, pick_idx(), pick_setting());
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0)
				send_noise();
			send_word(CMD_APPEND, pick_idx(), $urandom);
		end
		repeat ($urandom_range(2, 6))
			send_word(CMD_QUERY, pick_target(), $urandom);
	endtask

	// receiver: random stalls, plus one long hold when asked
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_LEN;
			end
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if (!steady && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (answer_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected result word %h", m_tdata);
			end else begin
				chk_exp = answer_q.pop_front();
				chk_loc = m_tdata[LOC_W-1:0];
				chk_st = m_tdata[STAT_LSB +: STAT_W];
				if (chk_loc !== chk_exp.loc || chk_st !== chk_exp.st) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: location exp %0d got %0d, status exp %0d got %0d",
							chk_exp.loc, chk_loc, chk_exp.st, chk_st);
				end
			end
		end
	end

	task automatic test_directed();
		set_config(6'd32, 32'h0);
		send_word(CMD_QUERY, 5'd0, 32'h0);
		send_word(CMD_WRITE, 5'd0, 32'hffff_ffff);
		send_word(CMD_WRITE, 5'd31, 32'h0);
		send_word(CMD_WRITE, 5'd5, 32'h0000_0403);
		send_word(CMD_WRITE, 5'd6, 32'h0000_0003);
		send_word(CMD_APPEND, 5'd5, 32'h0);
		send_word(CMD_APPEND, 5'd6, 32'hffff_ffff);
		send_word(CMD_APPEND, 5'd0, 32'h0);
		send_word(CMD_APPEND, 5'd31, 32'h0);
		// smooth group of location 3 collides with the flat one
		send_word(CMD_QUERY, 5'd6, 32'h0);
		send_word(CMD_QUERY, 5'd5, 32'h0);
		send_word(CMD_QUERY, 5'd0, 32'h0);
		send_word(CMD_QUERY, 5'd20, 32'hffff_ffff);
		// custom bits cancel flat
		set_config(6'd32, 32'hffff_ffff);
		send_word(CMD_QUERY, 5'd6, 32'h0);
		send_word(CMD_QUERY, 5'd0, 32'h0);
		// input count zero: no setting applies, every input maps to itself
		set_config(6'd0, 32'h0);
		send_word(CMD_QUERY, 5'd31, 32'h0);
		send_word(CMD_QUERY, 5'd5, 32'h0);
		send_word(CMD_CLEAR, 5'd31, 32'hffff_ffff);
		send_word(CMD_QUERY, 5'd5, 32'h0);
		send_word(CMD_WRITE, 5'd31, 32'hffff_ffff);
	endtask

	task automatic test_list_full();
		set_config(6'd32, 32'h0000_ffff);
		send_word(CMD_CLEAR, 5'd0, 32'h0);
		repeat (8)
			send_word(CMD_WRITE, pick_idx(), pick_setting());
		repeat (NACT + 3)
			send_word(CMD_APPEND, pick_idx(), $urandom);
		repeat (4)
			send_word(CMD_QUERY, pick_target(), $urandom);
		send_word(CMD_CLEAR, 5'd0, 32'h0);
		send_word(CMD_APPEND, 5'd3, 32'h0);
	endtask

	task automatic test_random_phases();
		int p;
		int s;
		for (p = 0; p < 6; p++) begin
			case (p)
				0: set_config(6'd32, 32'h0);
				1: set_config(6'd0, 32'hffff_ffff);
				2: set_config(6'd32, 32'hffff_ffff);
				3: set_config(6'd16, 32'h5555_aaaa);
				default: set_config(CNT_W'($urandom_range(1, 31)), $urandom);
			endcase
			for (s = 0; s < 4; s++) begin
				steady = (s == 2);
				if ($urandom_range(0, 5) == 0)
					run_scene($urandom_range(20, NACT + 2), 1'b1);
				else
					run_scene($urandom_range(1, 12), $urandom_range(0, 4) != 0);
			end
			steady = 1'b0;
		end
	endtask

	task automatic test_pressure();
		drain();
		@(posedge clk);
		hold_req = 1'b1;
		steady = 1'b1;
		repeat (12)
			send_word(cmd_t'($urandom_range(0, 3)), pick_idx(), pick_setting());
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_WRITE;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_INPUT_COUNT;
		cfg_data = '0;
		num_inputs = '0;
		custom_bits = '0;
		for (int i = 0; i < NUM_IDX; i++) begin
			tbl_loc[i] = '0;
			tbl_flat[i] = 1'b0;
		end
		for (int i = 0; i < NACT; i++)
			act_list[i] = '0;
		act_len = 0;
		n_err = 0;
		n_words = 0;
		n_queries = 0;
		n_moved = 0;
		n_full = 0;
		n_cfg = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		stall_left = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_list_full();
		test_pressure();
		test_random_phases();
		test_pressure();

		drain();
		repeat (200) @(posedge clk);
		if (answer_q.size() != 0) begin
			n_err++;
			$display("%0d expected results never arrived", answer_q.size());
		end
		$display("covered %0d words: %0d queries (%0d relocated), %0d full-list appends",
			n_words, n_queries, n_moved, n_full);
		$display("%0d config writes, %0d mismatches", n_cfg, n_err);
		if (n_err == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/pila_pkg.sv
sv/pila_ram.sv
sv/pixel_input_location_assigner.sv
sim/tb_top.sv
